@@ rtl/core/tkrs_pkg.sv @@
`timescale 1ns / 1ps

package tkrs_pkg;

	localparam int ID_W    = 22;
	localparam int PAGES_W = 32;
	localparam int RANK_W  = 6;

	// command codes of an input item
	localparam logic CMD_OFFER  = 1'b0;
	localparam logic CMD_REPORT = 1'b1;

	localparam logic [PAGES_W-1:0] COUNT_MAX = {PAGES_W{1'b1}};

	typedef struct packed {
		logic               cmd;
		logic [ID_W-1:0]    task_id;
		logic               has_memory;
		logic [PAGES_W-1:0] virtual_pages;
		logic [PAGES_W-1:0] resident_pages;
	} item_t;

	typedef struct packed {
		logic               slot_valid;
		logic [RANK_W-1:0]  rank;
		logic [ID_W-1:0]    out_task_id;
		logic [PAGES_W-1:0] out_virtual_pages;
		logic [PAGES_W-1:0] out_resident_pages;
		logic [PAGES_W-1:0] tasks_seen;
		logic               last;
	} result_t;

	// one stored list entry
	typedef struct packed {
		logic [ID_W-1:0]    task_id;
		logic [PAGES_W-1:0] virt;
		logic [PAGES_W-1:0] res;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic insert;
		logic shift_out;
		logic clear_count;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rank_last;
	} dp_stat_t;

endpackage

@@ rtl/core/tkrs_dpath.sv @@
`timescale 1ns / 1ps

module tkrs_dpath #(
	parameter int DEPTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tkrs_pkg::dp_cmd_t  cmd,
	input  tkrs_pkg::item_t    item,
	output tkrs_pkg::dp_stat_t stat,
	output tkrs_pkg::result_t  result
);
	import tkrs_pkg::*;

	logic [DEPTH-1:0] valid_q;
	logic [DEPTH-1:0] valid_d;
	entry_t           entry_q [DEPTH];
	entry_t           entry_d [DEPTH];
	logic [DEPTH-1:0] hit;

	logic [ID_W-1:0]    pend_id_q;
	logic [PAGES_W-1:0] pend_virt_q;
	logic [PAGES_W-1:0] pend_res_q;
	logic               pend_mem_q;
	logic [PAGES_W-1:0] count_q;
	logic [RANK_W-1:0]  rank_q;
	result_t            result_q;

	logic rank_last;
	assign rank_last      = (rank_q == RANK_W'(DEPTH - 1));
	assign stat.rank_last = rank_last;
	assign result         = result_q;

	// offered item held for the insert cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_id_q   <= item.task_id;
			pend_virt_q <= item.virtual_pages;
			pend_res_q  <= item.resident_pages;
			pend_mem_q  <= item.has_memory;
		end
	end

	// per-slot compare, list is a valid prefix sorted descending so hit is a suffix of ones
	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			hit[j] = !valid_q[j] || (pend_res_q >= entry_q[j].res);
		end
	end

	// next list: insert at first hit with shift down, or shift up during a report
	always_comb begin
		valid_d = valid_q;
		for (int j = 0; j < DEPTH; j++) begin
			entry_d[j] = entry_q[j];
		end
		if (cmd.insert && pend_mem_q) begin
			for (int j = 0; j < DEPTH; j++) begin
				if (hit[j] && (j == 0 || !hit[(j == 0) ? 0 : j - 1])) begin
					valid_d[j]         = 1'b1;
					entry_d[j].task_id = pend_id_q;
					entry_d[j].virt    = pend_virt_q;
					entry_d[j].res     = pend_res_q;
				end else if (j > 0 && hit[(j == 0) ? 0 : j - 1]) begin
					valid_d[j] = valid_q[(j == 0) ? 0 : j - 1];
					entry_d[j] = entry_q[(j == 0) ? 0 : j - 1];
				end
			end
		end else if (cmd.shift_out) begin
			for (int j = 0; j < DEPTH; j++) begin
				if (j == DEPTH - 1) begin
					valid_d[j] = 1'b0;
					entry_d[j] = '0;
				end else begin
					valid_d[j] = valid_q[(j == DEPTH - 1) ? 0 : j + 1];
					entry_d[j] = entry_q[(j == DEPTH - 1) ? 0 : j + 1];
				end
			end
		end
	end

	// list cells
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int j = 0; j < DEPTH; j++) begin
				entry_q[j] <= '0;
			end
		end else begin
			valid_q <= valid_d;
			for (int j = 0; j < DEPTH; j++) begin
				entry_q[j] <= entry_d[j];
			end
		end
	end

	// saturating task counter and report rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rank_q  <= '0;
		end else begin
			if (cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.insert && count_q != COUNT_MAX) begin
				count_q <= count_q + PAGES_W'(1);
			end
			if (cmd.shift_out) begin
				rank_q <= rank_last ? '0 : rank_q + RANK_W'(1);
			end
		end
	end

	// output register, top slot leaves on each shift
	always_ff @(posedge clk) begin
		if (cmd.shift_out) begin
			result_q.slot_valid         <= valid_q[0];
			result_q.rank               <= rank_q;
			result_q.out_task_id        <= valid_q[0] ? entry_q[0].task_id : '0;
			result_q.out_virtual_pages  <= valid_q[0] ? entry_q[0].virt : '0;
			result_q.out_resident_pages <= valid_q[0] ? entry_q[0].res : '0;
			result_q.tasks_seen         <= count_q;
			result_q.last               <= rank_last;
		end
	end

`ifndef SYNTH
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_q >> 1) & ~valid_q) == '0)
		else $error("valid slots not contiguous from rank 0");

	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q <= RANK_W'(DEPTH - 1))
		else $error("report rank beyond list depth");

	a_rank_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_out && rank_last |=> rank_q == '0 && valid_q == '0)
		else $error("list not empty after full report");
`endif

endmodule

@@ rtl/core/tkrs_ctrl.sv @@
`timescale 1ns / 1ps

module tkrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic               item_cmd,
	output logic               result_valid,
	input  logic               result_ready,
	input  tkrs_pkg::dp_stat_t stat,
	output tkrs_pkg::dp_cmd_t  cmd
);
	import tkrs_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_INSERT = 2'd1;
	localparam logic [1:0] S_REPORT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       load_out;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign load_out     = (state_q == S_REPORT) && (!out_valid_q || result_ready);

	// commands and next state
	always_comb begin
		state_d         = state_q;
		cmd.load        = 1'b0;
		cmd.insert      = 1'b0;
		cmd.shift_out   = 1'b0;
		cmd.clear_count = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (item_cmd == CMD_REPORT) ? S_REPORT : S_INSERT;
				end
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_IDLE;
			end
			S_REPORT: begin
				if (load_out) begin
					cmd.shift_out = 1'b1;
					if (stat.rank_last) begin
						cmd.clear_count = 1'b1;
						state_d         = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_offer_insert: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item_cmd == CMD_OFFER |=> cmd.insert && !result_valid || cmd.insert)
		else $error("offered item not inserted next cycle");

	a_insert_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> !cmd.insert && item_ready)
		else $error("insert not single cycle");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_count |-> cmd.shift_out && stat.rank_last)
		else $error("counter cleared outside last report slot");

	a_report_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_out |=> result_valid)
		else $error("report slot loaded but not presented");
`endif

endmodule

@@ rtl/core/top_k_by_resident_size.sv @@
`timescale 1ns / 1ps

// Top-K list of tasks ordered by resident page count, largest first.
// Input channel item/item_valid/item_ready: an item with cmd offer counts one
// task and, if it has a memory map, inserts it into the sorted list (ties put
// the newer task first, the smallest entry falls off a full list). An item
// with cmd report streams all DEPTH slots in rank order on the result channel
// result/result_valid/result_ready, then empties the list and the counter.
// An offer has the accept cycle and then an insert cycle in which every slot
// compares in parallel and the list shifts down; no result is produced.
// A report has the accept cycle, then one slot per cycle, unless the receiver
// stalls, moves from the head of the list into the output register as the
// list shifts up.
// The first slot becomes valid once the report state has loaded it into the output register.
// item_ready is high only while the controller is idle; a stalled receiver
// holds the output register and pauses the report, and the next item may be
// accepted while the last slot still waits to be taken.
// Reset empties the list, zeroes the task counter and drops result_valid.
module top_k_by_resident_size #(
	parameter int DEPTH = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tkrs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output tkrs_pkg::result_t result
);
	import tkrs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	tkrs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_cmd     (item.cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	// sorted list, counter and output register
	tkrs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

endmodule
